// ===== rtl/igfp_pkg.sv =====
// ----------------------------------------------------------------------------
// igfp_pkg: shared types and constants of the IMU/GPS frame parser
// Phase codes, status codes and the word passed from front to back.
// ----------------------------------------------------------------------------
package igfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 28;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] SYNC0    = 8'h44;
    localparam logic [7:0] SYNC1    = 8'h49;
    localparam logic [7:0] SYNC2    = 8'h59;
    localparam logic [7:0] SYNC3    = 8'h64;
    localparam logic [7:0] MSG_ATT  = 8'h02;
    localparam logic [7:0] MSG_POS  = 8'h03;
    localparam logic [7:0] MSG_ATTA = 8'h04;
    localparam logic [7:0] MSG_PERF = 8'h0a;

    typedef enum logic [3:0] {
        PH_HUNT, PH_S1, PH_S2, PH_S3, PH_LEN, PH_MSG, PH_PAY, PH_CKA, PH_CKB
    } phase_t;

    typedef enum logic [2:0] {
        ST_ATT, ST_POS, ST_ATTA, ST_PERF, ST_UNKNOWN, ST_CKSUM, ST_LEN
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE, OP_STORE, OP_EMIT
    } op_t;

    // Word from the front (classifier) to the back (store and decoder).
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [7:0] index;
        status_t    status;
    } cmd_t;

endpackage

// ===== rtl/igfp_front.sv =====
// ----------------------------------------------------------------------------
// igfp_front: sync hunt, length check and checksum
// Classifies each byte and issues store and emit commands to the back end.
// ----------------------------------------------------------------------------
module igfp_front
    import igfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] rx_byte,
    output cmd_t       cmd
);

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] kind_reg, kind_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] sa_reg, sa_next;
    logic [7:0] sb_reg, sb_next;
    logic [7:0] rsa_reg, rsa_next;
    logic [7:0] sa_add;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            len_reg   <= '0;
            kind_reg  <= '0;
            cnt_reg   <= '0;
            sa_reg    <= '0;
            sb_reg    <= '0;
            rsa_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            kind_reg  <= kind_next;
            cnt_reg   <= cnt_next;
            sa_reg    <= sa_next;
            sb_reg    <= sb_next;
            rsa_reg   <= rsa_next;
        end
    end

    assign sa_add = sa_reg + rx_byte;

    always_comb
    begin
        phase_next = PH_HUNT;
        len_next   = len_reg;
        kind_next  = kind_reg;
        cnt_next   = cnt_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        rsa_next   = rsa_reg;
        cmd.op     = OP_NONE;
        cmd.data   = rx_byte;
        cmd.index  = cnt_reg;
        cmd.status = ST_CKSUM;
        case (phase_reg)
            PH_S1: phase_next = (rx_byte == SYNC1) ? PH_S2 : PH_HUNT;
            PH_S2: phase_next = (rx_byte == SYNC2) ? PH_S3 : PH_HUNT;
            PH_S3: phase_next = (rx_byte == SYNC3) ? PH_LEN : PH_HUNT;
            PH_LEN:
            begin
                len_next = rx_byte;
                if (rx_byte > 8'(MAX_PAYLOAD))
                begin
                    cmd.op     = OP_EMIT;
                    cmd.status = ST_LEN;
                    cnt_next   = '0;
                    sa_next    = '0;
                    sb_next    = '0;
                end
                else
                begin
                    sa_next    = sa_add;
                    sb_next    = sb_reg + sa_add;
                    phase_next = PH_MSG;
                end
            end
            PH_MSG:
            begin
                kind_next  = rx_byte;
                sa_next    = sa_add;
                sb_next    = sb_reg + sa_add;
                phase_next = PH_PAY;
            end
            PH_PAY:
            begin
                if (cnt_reg < 8'(MAX_PAYLOAD))
                    cmd.op = OP_STORE;
                sa_next  = sa_add;
                sb_next  = sb_reg + sa_add;
                if (cnt_reg != 8'hff)
                    cnt_next = cnt_reg + 8'd1;
                phase_next = (cnt_next >= len_reg) ? PH_CKA : PH_PAY;
            end
            PH_CKA:
            begin
                rsa_next   = rx_byte;
                phase_next = PH_CKB;
            end
            PH_CKB:
            begin
                cmd.op = OP_EMIT;
                if (sa_reg != rsa_reg || sb_reg != rx_byte)
                    cmd.status = ST_CKSUM;
                else
                    case (kind_reg)
                        MSG_ATT:  cmd.status = ST_ATT;
                        MSG_POS:  cmd.status = ST_POS;
                        MSG_ATTA: cmd.status = ST_ATTA;
                        MSG_PERF: cmd.status = ST_PERF;
                        default:  cmd.status = ST_UNKNOWN;
                    endcase
                cnt_next = '0;
                sa_next  = '0;
                sb_next  = '0;
            end
            default: phase_next = (rx_byte == SYNC0) ? PH_S1 : PH_HUNT;
        endcase
    end

    a_len_reject: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_LEN && rx_byte > 8'(MAX_PAYLOAD)
        |=> phase_reg == PH_HUNT && sa_reg == 8'd0)
        else $error("length reject did not restart");
    a_emit_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_CKB |=> cnt_reg == 8'd0 && phase_reg == PH_HUNT)
        else $error("frame end did not restart");
    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_STORE |-> cmd.index < 8'(MAX_PAYLOAD))
        else $error("store beyond payload");

endmodule

// ===== rtl/igfp_queue.sv =====
// ----------------------------------------------------------------------------
// igfp_queue: short command queue between front and back
// Two-entry FIFO of command words with full and empty flags.
// ----------------------------------------------------------------------------
module igfp_queue
    import igfp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wr_cmd,
    input  logic pop,
    output cmd_t rd_cmd,
    output logic not_empty,
    output logic not_full
);

    cmd_t       mem_reg [QUEUE_DEPTH];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_cmd;
    end

    assign rd_cmd    = mem_reg[rp_reg];
    assign not_empty = (cnt_reg != 2'd0);
    assign not_full  = (cnt_reg != 2'(QUEUE_DEPTH));

    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> not_full || pop)
        else $error("queue overflow");
    a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue underflow");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== rtl/igfp_back.sv =====
// ----------------------------------------------------------------------------
// igfp_back: payload store and result decoder
// Executes store commands and builds result words into an output register.
// ----------------------------------------------------------------------------
module igfp_back
    import igfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cmd_t         cmd,
    input  logic         cmd_valid,
    output logic         cmd_pop,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [207:0] m_axis_tdata
);

    logic [7:0]   pay_reg [MAX_PAYLOAD];
    logic         ovalid_reg, ovalid_next;
    logic [207:0] odata_reg;
    logic [207:0] odata_next;
    logic         slot_free;
    logic [15:0]  w0, w2, w4, w6, w8, w10, w14, w16;
    logic [19:0]  alt;

    function automatic logic [7:0] pb(input int i);
        pb = (i < MAX_PAYLOAD) ? pay_reg[i] : 8'h00;
    endfunction

    assign slot_free = !ovalid_reg || m_axis_tready;
    assign cmd_pop   = cmd_valid && (cmd.op != OP_EMIT || slot_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < MAX_PAYLOAD; i++)
                pay_reg[i] <= 8'h00;
        else if (cmd_pop && cmd.op == OP_STORE)
            pay_reg[cmd.index[$clog2(MAX_PAYLOAD)-1:0]] <= cmd.data;
    end

    always_comb
    begin
        w0  = {pb(1), pb(0)};
        w2  = {pb(3), pb(2)};
        w4  = {pb(5), pb(4)};
        w6  = {pb(7), pb(6)};
        w8  = {pb(9), pb(8)};
        w10 = {pb(11), pb(10)};
        w14 = {pb(15), pb(14)};
        w16 = {pb(17), pb(16)};
        alt = 20'({{4{w8[15]}}, w8} <<< 3) + 20'({{4{w8[15]}}, w8} <<< 1);
        odata_next = '0;
        odata_next[2:0] = cmd.status;
        case (cmd.status)
            ST_ATT, ST_ATTA:
            begin
                odata_next[18:3]  = w0;
                odata_next[34:19] = w2;
                odata_next[50:35] = w4;
                if (cmd.status == ST_ATTA)
                    odata_next[66:51] = w6;
            end
            ST_POS:
            begin
                odata_next[98:67]   = {w2, w0};
                odata_next[130:99]  = {w6, w4};
                odata_next[150:131] = alt;
                odata_next[166:151] = w10;
                odata_next[198:167] = {w16, w14};
                odata_next[206:199] = pb(15);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (m_axis_tready)
            ovalid_next = 1'b0;
        if (cmd_pop && cmd.op == OP_EMIT)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else
            ovalid_reg <= ovalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.op == OP_EMIT)
            odata_reg <= odata_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !m_axis_tready |=> ovalid_reg && $stable(odata_reg))
        else $error("result lost under stall");
    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd.op == OP_EMIT |=> ovalid_reg)
        else $error("emit not shown");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg |-> odata_reg[2:0] != 3'd7)
        else $error("bad status code");

endmodule

// ===== rtl/imu_gps_frame_parser_unit.sv =====
// A frame's last byte queues an emit command; its result is then registered.
// One byte per cycle while the queue has room; front and back run concurrently.
// The two-entry command queue and the output register decouple input and output.
// Reset: asynchronous, active low; the parser returns to sync hunt and the
// payload store clears to zero.
// ----------------------------------------------------------------------------
// imu_gps_frame_parser_unit: top level of the IMU/GPS frame parser
// Front end classifies bytes, queue carries commands, back end decodes frames.
// ----------------------------------------------------------------------------
module imu_gps_frame_parser_unit
    import igfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,  // rx_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // frame_status, roll, pitch, heading, air_speed, longitude, latitude,
    // altitude, gnd_speed, fix_time, health, zero pad
    output logic [207:0] m_axis_tdata
);

    cmd_t fcmd, qcmd;
    logic in_fire, push, pop, q_ne, q_nf;

    assign s_axis_tready = q_nf;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign push          = in_fire && fcmd.op != OP_NONE;

    igfp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .rx_byte (s_axis_tdata),
        .cmd     (fcmd)
    );

    igfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_cmd    (fcmd),
        .pop       (pop),
        .rd_cmd    (qcmd),
        .not_empty (q_ne),
        .not_full  (q_nf)
    );

    igfp_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (qcmd),
        .cmd_valid     (q_ne),
        .cmd_pop       (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
